>>> design/rtree_quadratic_node_split_assert.svh
// Assertion macros shared by the split block.
`ifndef RTREE_QUADRATIC_NODE_SPLIT_ASSERT_SVH
`define RTREE_QUADRATIC_NODE_SPLIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RQS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rqs_pkg.sv
`default_nettype none
package rqs_pkg;
    localparam int MAX_ENTRIES    = 64;
    localparam int IDX_W          = $clog2(MAX_ENTRIES);
    localparam int CNT_W          = $clog2(MAX_ENTRIES + 1);
    localparam int COORD_W        = 20;
    localparam int REF_W          = 24;
    localparam int MF_W           = 6;
    localparam int SLOT_W         = 6;
    localparam int AREA_W         = 2 * (COORD_W + 1);
    localparam int SCORE_W        = AREA_W + 2;
    localparam int MIN_FILL_RESET = 25;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_pt;

    typedef struct packed {
        t_pt up;
        t_pt lo;
    } t_box;

    typedef struct packed {
        logic [REF_W-1:0] child;
        t_box             box;
    } t_entry;

    // Smallest box covering both boxes, taken per axis.
    function automatic t_box box_union(input t_box a, input t_box b);
        t_box r;
        r.lo.x = (a.lo.x < b.lo.x) ? a.lo.x : b.lo.x;
        r.lo.y = (a.lo.y < b.lo.y) ? a.lo.y : b.lo.y;
        r.up.x = (a.up.x > b.up.x) ? a.up.x : b.up.x;
        r.up.y = (a.up.y > b.up.y) ? a.up.y : b.up.y;
        return r;
    endfunction
endpackage
`default_nettype wire

>>> design/rqs_if.sv
`default_nettype none
// Entry words going into the block.
interface rqs_item_if;
    logic                          valid;
    logic                          ready;
    logic [rqs_pkg::COORD_W-1:0]   box_min_x;
    logic [rqs_pkg::COORD_W-1:0]   box_min_y;
    logic [rqs_pkg::COORD_W-1:0]   box_max_x;
    logic [rqs_pkg::COORD_W-1:0]   box_max_y;
    logic [rqs_pkg::REF_W-1:0]     child_ref;
    logic                          last_entry;
    modport source (output valid, box_min_x, box_min_y, box_max_x, box_max_y,
                    child_ref, last_entry, input ready);
    modport sink   (input valid, box_min_x, box_min_y, box_max_x, box_max_y,
                    child_ref, last_entry, output ready);
endinterface

// Assignment words coming out of the block.
interface rqs_result_if;
    logic                          valid;
    logic                          ready;
    logic                          group;
    logic [rqs_pkg::SLOT_W-1:0]    slot;
    logic [rqs_pkg::SLOT_W-1:0]    entry_index;
    logic [rqs_pkg::REF_W-1:0]     out_child_ref;
    logic [rqs_pkg::COORD_W-1:0]   out_min_x;
    logic [rqs_pkg::COORD_W-1:0]   out_min_y;
    logic [rqs_pkg::COORD_W-1:0]   out_max_x;
    logic [rqs_pkg::COORD_W-1:0]   out_max_y;
    logic                          overflow;
    logic                          last_result;
    modport source (output valid, group, slot, entry_index, out_child_ref, out_min_x,
                    out_min_y, out_max_x, out_max_y, overflow, last_result,
                    input ready);
    modport sink   (input valid, group, slot, entry_index, out_child_ref, out_min_x,
                    out_min_y, out_max_x, out_max_y, overflow, last_result,
                    output ready);
endinterface

// Configuration word carrying the minimum fill.
interface rqs_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rqs_pkg::MF_W-1:0]   min_fill;
    modport source (output valid, min_fill, input ready);
    modport sink   (input valid, min_fill, output ready);
endinterface
`default_nettype wire

>>> design/rtree_quadratic_node_split.sv
// Quadratic split of an overfull R-tree node. Entries are taken one word per
// cycle while i_item.ready is high; the word marked last_entry starts the split
// and the block takes no entry until the final assignment word has been taken.
// All areas come from one shared 21 x 21 bit area multiplier driven by a small
// sequencer. For n held entries the seed search visits every ordered pair of
// distinct entries and steps over the diagonal. Each later pick round scans
// the unassigned entries and then may wait on the output; once one group must
// take the rest, each entry is placed in turn, skipping assigned entries. Each
// assignment word waits in the output register until taken. Entries beyond 64
// are dropped and flagged in overflow.
// The minimum fill may be written at any time the block is idle.
`default_nettype none
module rtree_quadratic_node_split (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rqs_item_if.sink     i_item,
    rqs_cfg_if.sink      i_cfg,
    rqs_result_if.source o_result
);
    import rqs_pkg::*;

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_LOAD    = 5'd0;
    localparam logic [ST_W-1:0] S_START   = 5'd1;
    localparam logic [ST_W-1:0] S_SP_CHK  = 5'd2;
    localparam logic [ST_W-1:0] S_SP_A1   = 5'd3;
    localparam logic [ST_W-1:0] S_SP_A2   = 5'd4;
    localparam logic [ST_W-1:0] S_SP_A3   = 5'd5;
    localparam logic [ST_W-1:0] S_SP_CMP  = 5'd6;
    localparam logic [ST_W-1:0] S_SP_ADV  = 5'd7;
    localparam logic [ST_W-1:0] S_SEED_RD = 5'd8;
    localparam logic [ST_W-1:0] S_SEED_LD = 5'd9;
    localparam logic [ST_W-1:0] S_SEED2   = 5'd10;
    localparam logic [ST_W-1:0] S_PRD     = 5'd11;
    localparam logic [ST_W-1:0] S_PLACE   = 5'd12;
    localparam logic [ST_W-1:0] S_WAIT    = 5'd13;
    localparam logic [ST_W-1:0] S_ROUND   = 5'd14;
    localparam logic [ST_W-1:0] S_FL_CHK  = 5'd15;
    localparam logic [ST_W-1:0] S_PK_A0   = 5'd16;
    localparam logic [ST_W-1:0] S_PK_A1   = 5'd17;
    localparam logic [ST_W-1:0] S_PK_A2   = 5'd18;
    localparam logic [ST_W-1:0] S_PK_CHK  = 5'd19;
    localparam logic [ST_W-1:0] S_PK_RD   = 5'd20;
    localparam logic [ST_W-1:0] S_PK_D0   = 5'd21;
    localparam logic [ST_W-1:0] S_PK_D1   = 5'd22;
    localparam logic [ST_W-1:0] S_PK_CMP  = 5'd23;

    typedef struct packed {
        logic              group;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] entry_index;
        t_entry            entry;
        logic              overflow;
        logic              last_result;
    } t_result;

    logic [ST_W-1:0]         r_state;
    logic [ST_W-1:0]         r_ret;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_n;
    logic                    r_ovf;
    logic [MF_W-1:0]         r_min_fill;
    logic [MAX_ENTRIES-1:0]  r_assigned;
    logic [CNT_W-1:0]        r_i;
    logic [CNT_W-1:0]        r_j;
    logic [IDX_W-1:0]        r_s0;
    logic [IDX_W-1:0]        r_s1;
    logic                    r_have;
    logic signed [SCORE_W-1:0] r_acc;
    logic signed [SCORE_W-1:0] r_best;
    logic signed [SCORE_W-1:0] r_d0;
    logic signed [SCORE_W-1:0] r_d1;
    logic signed [AREA_W-1:0]  r_a0;
    logic signed [AREA_W-1:0]  r_a1;
    logic [IDX_W-1:0]        r_cand;
    logic                    r_cg;
    logic                    r_g;
    logic                    r_fg;
    t_box                    r_g0;
    t_box                    r_g1;
    logic [CNT_W-1:0]        r_c0;
    logic [CNT_W-1:0]        r_c1;
    logic                    r_ov;
    t_result                 r_out;

    t_entry                  wdata;
    t_entry                  rd_a;
    t_entry                  rd_b;
    logic                    item_acc;
    logic                    store_we;
    t_box                    unit_box;
    logic signed [AREA_W-1:0] area;
    logic signed [SCORE_W-1:0] area_x;
    logic signed [SCORE_W-1:0] waste;
    logic signed [SCORE_W-1:0] diff;
    logic                    pick_g;
    logic [CNT_W:0]          placed_next;
    logic                    place_last;
    logic [CNT_W-1:0]        fill0;
    logic [CNT_W-1:0]        fill1;
    logic [CNT_W-1:0]        mf_ext;

    // Entry store and shared area unit.
    assign wdata.child       = i_item.child_ref;
    assign wdata.box.lo.x    = i_item.box_min_x;
    assign wdata.box.lo.y    = i_item.box_min_y;
    assign wdata.box.up.x    = i_item.box_max_x;
    assign wdata.box.up.y    = i_item.box_max_y;
    assign item_acc          = i_item.valid && i_item.ready;
    assign store_we          = item_acc && (r_count < CNT_W'(MAX_ENTRIES));

    rqs_entry_store u_store (
        .i_clk     (i_clk),
        .i_we      (store_we),
        .i_waddr   (r_count[IDX_W-1:0]),
        .i_wdata   (wdata),
        .i_raddr_a (r_i[IDX_W-1:0]),
        .i_raddr_b (r_j[IDX_W-1:0]),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // The box fed to the multiplier depends on the step in hand.
    always_comb begin
        unique case (r_state)
            S_SP_A2: unit_box = rd_b.box;
            S_SP_A3: unit_box = box_union(rd_a.box, rd_b.box);
            S_PK_A0: unit_box = r_g0;
            S_PK_A1: unit_box = r_g1;
            S_PK_RD: unit_box = box_union(r_g0, rd_a.box);
            S_PK_D0: unit_box = box_union(r_g1, rd_a.box);
            default: unit_box = rd_a.box;
        endcase
    end

    rqs_area_unit u_area (
        .i_clk  (i_clk),
        .i_box  (unit_box),
        .o_area (area)
    );

    // Derived figures for compares.
    assign area_x      = SCORE_W'(area);
    assign waste       = r_acc + area_x;
    assign diff        = (r_d0 > r_d1) ? (r_d0 - r_d1) : (r_d1 - r_d0);
    assign placed_next = {1'b0, r_c0} + {1'b0, r_c1} + (CNT_W+1)'(1);
    assign place_last  = (placed_next == {1'b0, r_n});
    assign fill0       = r_n - r_c1;
    assign fill1       = r_n - r_c0;
    assign mf_ext      = CNT_W'(r_min_fill);

    // Group choice: smaller enlargement, then smaller area, then fewer entries.
    always_comb begin
        priority if (r_d0 != r_d1) begin
            pick_g = !(r_d0 < r_d1);
        end else if (r_a0 != r_a1) begin
            pick_g = !(r_a0 < r_a1);
        end else if (r_c0 != r_c1) begin
            pick_g = !(r_c0 < r_c1);
        end else begin
            pick_g = 1'b0;
        end
    end

    // Handshakes.
    assign i_item.ready = (r_state == S_LOAD);
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid         = r_ov;
    assign o_result.group         = r_out.group;
    assign o_result.slot          = r_out.slot;
    assign o_result.entry_index   = r_out.entry_index;
    assign o_result.out_child_ref = r_out.entry.child;
    assign o_result.out_min_x     = r_out.entry.box.lo.x;
    assign o_result.out_min_y     = r_out.entry.box.lo.y;
    assign o_result.out_max_x     = r_out.entry.box.up.x;
    assign o_result.out_max_y     = r_out.entry.box.up.y;
    assign o_result.overflow      = r_out.overflow;
    assign o_result.last_result   = r_out.last_result;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_ret      <= S_LOAD;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_min_fill <= MF_W'(MIN_FILL_RESET);
            r_assigned <= '0;
            r_ov       <= 1'b0;
            r_have     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_min_fill <= i_cfg.min_fill;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (item_acc) begin
                        if (store_we) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_item.last_entry) begin
                            r_n     <= store_we ? (r_count + CNT_W'(1)) : r_count;
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_assigned <= '0;
                    r_c0       <= '0;
                    r_c1       <= '0;
                    r_have     <= 1'b0;
                    r_i        <= '0;
                    r_j        <= '0;
                    if (r_n < CNT_W'(2)) begin
                        r_g     <= 1'b0;
                        r_state <= S_PRD;
                    end else begin
                        r_state <= S_SP_CHK;
                    end
                end
                // Seed search over ordered pairs, diagonal skipped.
                S_SP_CHK: begin
                    if (r_i == r_n) begin
                        r_i     <= CNT_W'(r_s0);
                        r_j     <= CNT_W'(r_s1);
                        r_state <= S_SEED_RD;
                    end else if (r_i == r_j) begin
                        r_state <= S_SP_ADV;
                    end else begin
                        r_state <= S_SP_A1;
                    end
                end
                S_SP_A1: r_state <= S_SP_A2;
                S_SP_A2: begin
                    r_acc   <= -area_x;
                    r_state <= S_SP_A3;
                end
                S_SP_A3: begin
                    r_acc   <= r_acc - area_x;
                    r_state <= S_SP_CMP;
                end
                S_SP_CMP: begin
                    if (!r_have || (waste >= r_best)) begin
                        r_have <= 1'b1;
                        r_best <= waste;
                        r_s0   <= r_i[IDX_W-1:0];
                        r_s1   <= r_j[IDX_W-1:0];
                    end
                    r_state <= S_SP_ADV;
                end
                S_SP_ADV: begin
                    if (r_j + CNT_W'(1) == r_n) begin
                        r_j <= '0;
                        r_i <= r_i + CNT_W'(1);
                    end else begin
                        r_j <= r_j + CNT_W'(1);
                    end
                    r_state <= S_SP_CHK;
                end
                S_SEED_RD: r_state <= S_SEED_LD;
                S_SEED_LD: begin
                    r_g0    <= rd_a.box;
                    r_g1    <= rd_b.box;
                    r_g     <= 1'b0;
                    r_ret   <= S_SEED2;
                    r_state <= S_PLACE;
                end
                S_SEED2: begin
                    r_i     <= CNT_W'(r_s1);
                    r_g     <= 1'b1;
                    r_ret   <= S_ROUND;
                    r_state <= S_PRD;
                end
                S_PRD: r_state <= S_PLACE;
                // Place the entry on port A into group r_g and present its word.
                S_PLACE: begin
                    r_assigned[r_i[IDX_W-1:0]] <= 1'b1;
                    r_out.group       <= r_g;
                    r_out.slot        <= SLOT_W'(r_g ? r_c1 : r_c0);
                    r_out.entry_index <= SLOT_W'(r_i);
                    r_out.entry       <= rd_a;
                    r_out.overflow    <= r_ovf;
                    r_out.last_result <= place_last;
                    if (r_g) begin
                        r_g1 <= box_union(r_g1, rd_a.box);
                        r_c1 <= r_c1 + CNT_W'(1);
                    end else begin
                        r_g0 <= box_union(r_g0, rd_a.box);
                        r_c0 <= r_c0 + CNT_W'(1);
                    end
                    r_ov    <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (o_result.ready) begin
                        r_ov <= 1'b0;
                        if (r_out.last_result) begin
                            r_count    <= '0;
                            r_ovf      <= 1'b0;
                            r_assigned <= '0;
                            r_state    <= S_LOAD;
                        end else begin
                            r_state <= r_ret;
                        end
                    end
                end
                // Either one group must take the rest, or pick the next entry.
                S_ROUND: begin
                    priority if (fill0 <= mf_ext) begin
                        r_fg    <= 1'b0;
                        r_i     <= '0;
                        r_state <= S_FL_CHK;
                    end else if (fill1 <= mf_ext) begin
                        r_fg    <= 1'b1;
                        r_i     <= '0;
                        r_state <= S_FL_CHK;
                    end else begin
                        r_state <= S_PK_A0;
                    end
                end
                S_FL_CHK: begin
                    if (r_assigned[r_i[IDX_W-1:0]]) begin
                        r_i <= r_i + CNT_W'(1);
                    end else begin
                        r_g     <= r_fg;
                        r_ret   <= S_FL_CHK;
                        r_state <= S_PRD;
                    end
                end
                S_PK_A0: r_state <= S_PK_A1;
                S_PK_A1: begin
                    r_a0    <= area;
                    r_state <= S_PK_A2;
                end
                S_PK_A2: begin
                    r_a1    <= area;
                    r_i     <= '0;
                    r_have  <= 1'b0;
                    r_state <= S_PK_CHK;
                end
                S_PK_CHK: begin
                    if (r_i == r_n) begin
                        r_i     <= CNT_W'(r_cand);
                        r_g     <= r_cg;
                        r_ret   <= S_ROUND;
                        r_state <= S_PRD;
                    end else if (r_assigned[r_i[IDX_W-1:0]]) begin
                        r_i <= r_i + CNT_W'(1);
                    end else begin
                        r_state <= S_PK_RD;
                    end
                end
                S_PK_RD: r_state <= S_PK_D0;
                S_PK_D0: begin
                    r_d0    <= area_x - SCORE_W'(r_a0);
                    r_state <= S_PK_D1;
                end
                S_PK_D1: begin
                    r_d1    <= area_x - SCORE_W'(r_a1);
                    r_state <= S_PK_CMP;
                end
                S_PK_CMP: begin
                    if (!r_have || (diff > r_best)) begin
                        r_have <= 1'b1;
                        r_best <= diff;
                        r_cand <= r_i[IDX_W-1:0];
                        r_cg   <= pick_g;
                    end
                    r_i     <= r_i + CNT_W'(1);
                    r_state <= S_PK_CHK;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    `include "rtree_quadratic_node_split_assert.svh"

    `RQS_ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, o_result.valid, !i_item.ready, "entry taken while a word waits")
    `RQS_ASSERT_NEXT(a_last_frees, i_clk, i_rst_n, o_result.valid && o_result.ready && o_result.last_result, i_item.ready, "block not free after final word")
    `RQS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, o_result.valid, ({1'b0, r_c0} + {1'b0, r_c1}) <= {1'b0, r_n}, "more entries placed than held")
endmodule
`default_nettype wire

>>> design/rqs_area_unit.sv
`default_nettype none
// Shared area unit: signed width times signed height, registered.
module rqs_area_unit (
    input  wire logic                        i_clk,
    input  wire rqs_pkg::t_box               i_box,
    output logic signed [rqs_pkg::AREA_W-1:0] o_area
);
    import rqs_pkg::*;

    logic signed [COORD_W:0] w;
    logic signed [COORD_W:0] h;

    // Extents may be negative for an inverted box.
    assign w = $signed({1'b0, i_box.up.x}) - $signed({1'b0, i_box.lo.x});
    assign h = $signed({1'b0, i_box.up.y}) - $signed({1'b0, i_box.lo.y});

    always_ff @(posedge i_clk) begin
        o_area <= w * h;
    end
endmodule
`default_nettype wire

>>> design/rqs_entry_store.sv
`default_nettype none
// Entry memory: one write port, two registered read ports.
module rqs_entry_store (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [rqs_pkg::IDX_W-1:0] i_waddr,
    input  wire rqs_pkg::t_entry           i_wdata,
    input  wire logic [rqs_pkg::IDX_W-1:0] i_raddr_a,
    input  wire logic [rqs_pkg::IDX_W-1:0] i_raddr_b,
    output rqs_pkg::t_entry                o_rdata_a,
    output rqs_pkg::t_entry                o_rdata_b
);
    import rqs_pkg::*;

    t_entry mem [MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end
endmodule
`default_nettype wire
